>>> hw/rtl/wrrs_pkg.sv
// Shared types and constants of the weighted round-robin splitter.
package wrrs_pkg;

    localparam int MODE_W      = 2;
    localparam int MASK_W      = 8;
    localparam int BRANCH_W    = 3;
    localparam int COUNT_W     = 8;
    localparam int BCOUNT_W    = 4;
    localparam int LANE_W      = 8;
    localparam int WEIGHTS_W   = 64;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE        = 2'd0,
        MODE_DUPLICATE   = 2'd1,
        MODE_ROUND_ROBIN = 2'd2,
        MODE_WEIGHTED    = 2'd3
    } t_mode;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPLIT_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRANCH_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRANCH_WEIGHTS = 2'd2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

>>> hw/rtl/wrrs_queue.sv
// Short word queue between the routing front and the result port.
module wrrs_queue #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [WIDTH-1:0]               i_wr_data,
    input  logic                           i_rd_en,
    output logic [WIDTH-1:0]               o_rd_data,
    output wrrs_pkg::t_queue_status        o_status
);
    import wrrs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_fire;
    logic             rd_fire;

    assign o_status.full  = (r_count == FULLC);
    assign o_status.empty = (r_count == '0);
    assign wr_fire        = i_wr_en && !o_status.full;
    assign rd_fire        = i_rd_en && !o_status.empty;
    assign o_rd_data      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_fire) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_fire && !rd_fire) begin
                r_count <= r_count + 1'b1;
            end else if (rd_fire && !wr_fire) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/wrrs_front.sv
// Configuration registers and branch selection for each accepted word.
module wrrs_front #(
    parameter int DATA_WIDTH   = 32,
    parameter int MAX_BRANCHES = 8,
    parameter int WEIGHT_WIDTH = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wrrs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [wrrs_pkg::WEIGHTS_W-1:0]    i_cfg_data,
    input  logic                              i_push,
    input  logic [DATA_WIDTH-1:0]             i_data_word,
    input  wrrs_pkg::t_queue_status           i_status,
    output logic                              o_wr_en,
    output logic [wrrs_pkg::MASK_W-1:0]       o_wr_mask,
    output logic [DATA_WIDTH-1:0]             o_wr_word
);
    import wrrs_pkg::*;

    localparam logic [BCOUNT_W-1:0] MAX_N = BCOUNT_W'(MAX_BRANCHES);
    localparam logic [LANE_W-1:0]   WMASK = LANE_W'((9'd1 << WEIGHT_WIDTH) - 9'd1);

    t_mode                r_split_mode;
    logic [BCOUNT_W-1:0]  r_branch_count;
    logic [WEIGHTS_W-1:0] r_branch_weights;
    logic [BRANCH_W-1:0]  r_cur;
    logic [COUNT_W-1:0]   r_wib;
    logic [BRANCH_W-1:0]  n_cur;
    logic [COUNT_W-1:0]   n_wib;

    logic [BCOUNT_W-1:0]  active_n;
    logic                 ptr_out;
    logic [BRANCH_W-1:0]  cur_eff;
    logic [COUNT_W-1:0]   wib_eff;
    logic [LANE_W-1:0]    weight [MASK_W];
    logic [MASK_W-1:0]    nz;
    logic                 found_hi;
    logic                 found_lo;
    logic [BRANCH_W-1:0]  idx_hi;
    logic [BRANCH_W-1:0]  idx_lo;
    logic                 found;
    logic [BRANCH_W-1:0]  found_idx;
    logic                 exhausted;
    logic [BRANCH_W-1:0]  target;
    logic [BCOUNT_W-1:0]  target_inc;
    logic [BRANCH_W-1:0]  next_t;
    logic [COUNT_W-1:0]   wib_inc;
    logic                 emit;
    logic [MASK_W-1:0]    mask;
    logic                 fire;

    always_comb begin
        if (r_branch_count == '0) begin
            active_n = BCOUNT_W'(1);
        end else if (r_branch_count > MAX_N) begin
            active_n = MAX_N;
        end else begin
            active_n = r_branch_count;
        end
    end

    assign ptr_out = ({1'b0, r_cur} >= active_n);
    assign cur_eff = ptr_out ? '0 : r_cur;
    assign wib_eff = ptr_out ? '0 : r_wib;

    always_comb begin
        for (int k = 0; k < MASK_W; k++) begin
            weight[k] = r_branch_weights[k*LANE_W +: LANE_W] & WMASK;
            nz[k]     = (weight[k] != '0) && (BCOUNT_W'(k) < active_n);
        end
    end

    always_comb begin
        found_hi = 1'b0;
        found_lo = 1'b0;
        idx_hi   = '0;
        idx_lo   = '0;
        for (int k = MASK_W - 1; k >= 0; k--) begin
            if (nz[k] && (BRANCH_W'(k) > cur_eff)) begin
                found_hi = 1'b1;
                idx_hi   = BRANCH_W'(k);
            end
            if (nz[k] && (BRANCH_W'(k) <= cur_eff)) begin
                found_lo = 1'b1;
                idx_lo   = BRANCH_W'(k);
            end
        end
    end

    assign found      = found_hi || found_lo;
    assign found_idx  = found_hi ? idx_hi : idx_lo;
    assign exhausted  = (wib_eff >= weight[cur_eff]);
    assign target     = (r_split_mode == MODE_WEIGHTED && exhausted) ? found_idx : cur_eff;
    assign target_inc = {1'b0, target} + BCOUNT_W'(1);
    assign next_t     = (target_inc >= active_n) ? '0 : target_inc[BRANCH_W-1:0];
    assign wib_inc    = (exhausted ? '0 : wib_eff) + COUNT_W'(1);

    always_comb begin
        emit  = 1'b0;
        mask  = '0;
        n_cur = r_cur;
        n_wib = r_wib;
        unique case (r_split_mode)
            MODE_NONE: begin
            end
            MODE_DUPLICATE: begin
                emit = 1'b1;
                mask = MASK_W'((9'd1 << active_n) - 9'd1);
            end
            MODE_ROUND_ROBIN: begin
                emit  = 1'b1;
                mask  = MASK_W'(1) << target;
                n_cur = next_t;
                n_wib = '0;
            end
            MODE_WEIGHTED: begin
                if (exhausted && !found) begin
                    n_cur = cur_eff;
                    n_wib = wib_eff;
                end else begin
                    emit = 1'b1;
                    mask = MASK_W'(1) << target;
                    if (wib_inc >= weight[target]) begin
                        n_cur = next_t;
                        n_wib = '0;
                    end else begin
                        n_cur = target;
                        n_wib = wib_inc;
                    end
                end
            end
        endcase
    end

    assign fire      = i_push && !i_status.full;
    assign o_wr_en   = fire && emit;
    assign o_wr_mask = mask;
    assign o_wr_word = i_data_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_mode     <= MODE_NONE;
            r_branch_count   <= BCOUNT_W'(1);
            r_branch_weights <= '0;
            r_cur            <= '0;
            r_wib            <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SPLIT_MODE:     r_split_mode     <= t_mode'(i_cfg_data[MODE_W-1:0]);
                    CFG_BRANCH_COUNT:   r_branch_count   <= i_cfg_data[BCOUNT_W-1:0];
                    CFG_BRANCH_WEIGHTS: r_branch_weights <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (fire) begin
                r_cur <= n_cur;
                r_wib <= n_wib;
            end
        end
    end

endmodule

>>> hw/rtl/weighted_round_robin_splitter.sv
// Top level of the weighted round-robin splitter: routing front and result queue.
// A routed word is queued and reaches the result ports after earlier words are popped.
// Throughput: one word per cycle while not full; the branch search is combinational.
// Dropped words leave nothing in the queue.
// Reset selects mode none with one branch and zero weights, clears the routing position
// and empties the queue.
module weighted_round_robin_splitter #(
    parameter int DATA_WIDTH   = 32,
    parameter int MAX_BRANCHES = 8,
    parameter int WEIGHT_WIDTH = 8,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wrrs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [wrrs_pkg::WEIGHTS_W-1:0]    i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [DATA_WIDTH-1:0]             i_data_word,
    output logic                              empty,
    input  logic                              pop,
    output logic [wrrs_pkg::MASK_W-1:0]       o_branch_mask,
    output logic [DATA_WIDTH-1:0]             o_routed_word
);
    import wrrs_pkg::*;

    localparam int QW = MASK_W + DATA_WIDTH;

    t_queue_status         q_status;
    logic                  wr_en;
    logic [MASK_W-1:0]     wr_mask;
    logic [DATA_WIDTH-1:0] wr_word;
    logic [QW-1:0]         rd_data;

    wrrs_front #(
        .DATA_WIDTH   (DATA_WIDTH),
        .MAX_BRANCHES (MAX_BRANCHES),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_data_word (i_data_word),
        .i_status    (q_status),
        .o_wr_en     (wr_en),
        .o_wr_mask   (wr_mask),
        .o_wr_word   (wr_word)
    );

    wrrs_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_data ({wr_mask, wr_word}),
        .i_rd_en   (pop),
        .o_rd_data (rd_data),
        .o_status  (q_status)
    );

    assign full          = q_status.full;
    assign empty         = q_status.empty;
    assign o_branch_mask = rd_data[QW-1:DATA_WIDTH];
    assign o_routed_word = rd_data[DATA_WIDTH-1:0];

    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("Queue not empty after reset.");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("Queue reports full and empty together.");

    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_branch_mask != '0))
        else $error("Waiting word has no target branch.");

    a_empty_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && wr_en) |=> !empty)
        else $error("Routed word did not reach the queue.");

endmodule
